// ===== sv/icp_pkg.sv =====
// Shared types, character codes and helper functions for the infix-to-postfix
// converter. No dependencies; every other file imports this package.
package icp_pkg;

    // Default operator stack depth
    localparam int DEFAULT_STACK_DEPTH = 32;

    // Depth of the small queues at the input and at the result side
    localparam int QUEUE_DEPTH = 2;

    // ASCII codes of the recognized characters
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_TIMES   = 8'h2A;
    localparam logic [7:0] CH_DIVIDE  = 8'h2F;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Stack symbol codes; openers sit below the operators
    typedef enum logic [2:0] {
        SYM_PAREN  = 3'd0,
        SYM_SQUARE = 3'd1,
        SYM_CURLY  = 3'd2,
        SYM_PLUS   = 3'd3,
        SYM_MINUS  = 3'd4,
        SYM_TIMES  = 3'd5,
        SYM_DIVIDE = 3'd6,
        SYM_NONE   = 3'd7
    } t_sym;

    // Expression status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    // Classified input item, passed from front to back
    typedef struct packed {
        logic [7:0] ch;
        t_sym       sym;
        logic       closer;
        logic       last;
    } t_item;

    // One result item
    typedef struct packed {
        logic [7:0] ch;
        logic       term;
        t_status    status;
    } t_result;

    function automatic logic is_opener(input t_sym s);
        return (s == SYM_PAREN) || (s == SYM_SQUARE) || (s == SYM_CURLY);
    endfunction

    // High precedence for * and /
    function automatic logic prec_hi(input t_sym s);
        return (s == SYM_TIMES) || (s == SYM_DIVIDE);
    endfunction

    function automatic logic [7:0] sym_char(input t_sym s);
        logic [7:0] c;
        unique case (s)
            SYM_PAREN:  c = CH_LPAREN;
            SYM_SQUARE: c = CH_LSQUARE;
            SYM_CURLY:  c = CH_LCURLY;
            SYM_PLUS:   c = CH_PLUS;
            SYM_MINUS:  c = CH_MINUS;
            SYM_TIMES:  c = CH_TIMES;
            SYM_DIVIDE: c = CH_DIVIDE;
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic t_item classify(input logic [7:0] ch, input logic last);
        t_item it;
        it.ch     = ch;
        it.last   = last;
        it.closer = 1'b0;
        unique case (ch)
            CH_LPAREN:  it.sym = SYM_PAREN;
            CH_LSQUARE: it.sym = SYM_SQUARE;
            CH_LCURLY:  it.sym = SYM_CURLY;
            CH_RPAREN: begin
                it.sym    = SYM_PAREN;
                it.closer = 1'b1;
            end
            CH_RSQUARE: begin
                it.sym    = SYM_SQUARE;
                it.closer = 1'b1;
            end
            CH_RCURLY: begin
                it.sym    = SYM_CURLY;
                it.closer = 1'b1;
            end
            CH_PLUS:    it.sym = SYM_PLUS;
            CH_MINUS:   it.sym = SYM_MINUS;
            CH_TIMES:   it.sym = SYM_TIMES;
            CH_DIVIDE:  it.sym = SYM_DIVIDE;
            default:    it.sym = SYM_NONE;
        endcase
        return it;
    endfunction

endpackage

// ===== sv/icp_front.sv =====
// Front end: classifies each incoming character and holds it in a short queue
// until the stack engine takes it. Depends on icp_pkg.
module icp_front import icp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       full,
    output t_item      o_head,
    output logic       o_head_valid,
    input  logic       i_head_take
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_buf [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           accept;

    // Queue status toward both sides
    assign full         = (r_cnt == CW'(QUEUE_DEPTH));
    assign accept       = push && !full;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_buf[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = accept      ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = i_head_take ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_cnt    = r_cnt + CW'(accept) - CW'(i_head_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the classified item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[r_wr_ptr] <= classify(i_in_char, i_in_last);
        end
    end

endmodule

// ===== sv/icp_result_q.sv =====
// Result queue: holds finished postfix results until the consumer pops them,
// so the stack engine keeps working while a result waits. Depends on icp_pkg.
module icp_result_q import icp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result        r_buf [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           rd;

    assign o_full = (r_cnt == CW'(QUEUE_DEPTH));
    assign empty  = (r_cnt == '0);
    assign rd     = pop && !empty;
    assign o_head = r_buf[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = i_wr ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = rd   ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_cnt    = r_cnt + CW'(i_wr) - CW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the result
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ===== sv/icp_back.sv =====
// Stack engine: runs the shunting-yard steps for each classified item, one
// stack push or pop per cycle while the result queue is not full, with the top two
// entries kept in registers. Depends on icp_pkg.
module icp_back import icp_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_head,
    input  logic    i_head_valid,
    output logic    o_head_take,
    output logic    o_res_wr,
    output t_result o_res,
    input  logic    i_res_full
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    t_status        r_err, n_err;
    t_sym           r_top;
    t_sym           r_below;
    t_sym           mem [STACK_DEPTH];

    logic           room;
    logic           top_is_op;
    logic           do_push;
    logic           do_pop;
    logic           push_req;
    logic           finish;
    logic           mismatch;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign room      = !i_res_full;
    assign top_is_op = (r_count != '0) && !is_opener(r_top);
    assign wr_addr   = AW'(r_count - CW'(1));
    assign rd_addr   = AW'(r_count - CW'(3));

    // Sequence one step of the current item
    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        o_head_take = 1'b0;
        o_res_wr    = 1'b0;
        o_res.ch     = CH_NUL;
        o_res.term   = 1'b0;
        o_res.status = r_err;
        do_pop      = 1'b0;
        push_req    = 1'b0;
        finish      = 1'b0;
        mismatch    = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (i_head_valid) begin
                    priority if (i_head.sym == SYM_NONE) begin
                        // operand: copy through
                        if (room) begin
                            o_res_wr = 1'b1;
                            o_res.ch = i_head.ch;
                            finish   = 1'b1;
                        end
                    end else if (i_head.closer) begin
                        // pop operators down to the opener, then drop it
                        if (top_is_op) begin
                            if (room) begin
                                o_res_wr = 1'b1;
                                o_res.ch = sym_char(r_top);
                                do_pop   = 1'b1;
                            end
                        end else begin
                            if (r_count == '0) begin
                                mismatch = 1'b1;
                            end else begin
                                do_pop   = 1'b1;
                                mismatch = (r_top != i_head.sym);
                            end
                            finish = 1'b1;
                        end
                    end else if (is_opener(i_head.sym)) begin
                        push_req = 1'b1;
                        finish   = 1'b1;
                    end else begin
                        // operator: pop equal or higher precedence first
                        if (top_is_op && (prec_hi(r_top) || !prec_hi(i_head.sym))) begin
                            if (room) begin
                                o_res_wr = 1'b1;
                                o_res.ch = sym_char(r_top);
                                do_pop   = 1'b1;
                            end
                        end else begin
                            push_req = 1'b1;
                            finish   = 1'b1;
                        end
                    end
                    if (finish) begin
                        o_head_take = 1'b1;
                        if (i_head.last) begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (r_count != '0) begin
                    // unclosed openers drop and flag a mismatch, operators go out
                    if (is_opener(r_top)) begin
                        do_pop   = 1'b1;
                        mismatch = 1'b1;
                    end else if (room) begin
                        o_res_wr = 1'b1;
                        o_res.ch = sym_char(r_top);
                        do_pop   = 1'b1;
                    end
                end else if (room) begin
                    // terminator closes the expression
                    o_res_wr   = 1'b1;
                    o_res.term = 1'b1;
                    n_state    = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase

        // Push with overflow check
        do_push = push_req && (r_count != CW'(STACK_DEPTH));

        // Keep the first error of the expression
        if (r_err == ST_OK) begin
            if (mismatch) begin
                n_err = ST_MISMATCH;
            end else if (push_req && !do_push) begin
                n_err = ST_OVERFLOW;
            end
        end

        // Update the stack count; the terminator also clears the error
        priority if (o_res_wr && o_res.term) begin
            n_count = '0;
            n_err   = ST_OK;
        end else if (do_push) begin
            n_count = r_count + CW'(1);
        end else if (do_pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_count <= '0;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // Top register, next-below register and the spill memory below them
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            if (r_count != '0) begin
                mem[wr_addr] <= r_top;
            end
            r_top   <= i_head.sym;
            r_below <= r_top;
        end else if (do_pop) begin
            r_top   <= r_below;
            r_below <= mem[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_wr |-> !i_res_full)
        else $error("result written into a full queue");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_take |-> (i_head_valid && r_state == S_RUN))
        else $error("item taken with no item waiting");

    a_term_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.term) |=> (r_count == '0 && r_err == ST_OK && r_state == S_RUN))
        else $error("expression state not cleared after terminator");

endmodule

// ===== sv/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter: one ASCII character in, postfix characters out.
// An accepted operand is registered in the input queue, then passed by the stack engine
// into the result queue. The stack engine does one stack step per cycle while the result
// queue is not full; an item takes one step plus one per operator it pops, the last item adds
// one per stacked entry and one for the terminator, as the operator stack has a single push/pop port.
// Reset: synchronous, clears both queues, stack count and status; stack memory is not cleared.
module infix_to_postfix_converter import icp_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_out_end,
    output logic [1:0] o_out_status
);

    t_item   head;
    logic    head_valid;
    logic    head_take;
    logic    res_wr;
    t_result res;
    logic    res_full;
    t_result res_head;

    // Classify and queue input characters
    icp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .i_in_char    (i_in_char),
        .i_in_last    (i_in_last),
        .full         (full),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_head_take  (head_take)
    );

    // Run the operator stack
    icp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_take  (head_take),
        .o_res_wr     (res_wr),
        .o_res        (res),
        .i_res_full   (res_full)
    );

    // Hold results for the consumer
    icp_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_head  (res_head)
    );

    assign o_out_char   = res_head.ch;
    assign o_out_end    = res_head.term;
    assign o_out_status = res_head.status;

endmodule
